// ----- design/ptmp_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the priority table.
`timescale 1ns / 1ps
package ptmp_pkg;

  localparam int ID_COUNT      = 256;
  localparam int ID_BITS       = $clog2(ID_COUNT);
  localparam int PRIORITY_BITS = 16;
  localparam int ID_FIELD_BITS = 8;
  localparam int PRIO_FIELD_BITS = 16;

  // Request operation codes.
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef logic [ID_BITS-1:0]       id_t;
  typedef logic [PRIORITY_BITS-1:0] prio_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_set;   // store the priority of an accepted set request
    logic scan_start;  // clear the running best and the scan counter
    logic scan_issue;  // read the entry at the scan counter and advance
    logic commit;      // load the result register and remove the winner
  } ptmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;   // the entry being read this cycle is the last one
    logic out_free;    // the result register can take a new result
  } ptmp_status_t;

endpackage

// ----- design/ptmp_ctrl.sv -----
// Controller state machine: accepts requests and sequences the poll scan.
`timescale 1ns / 1ps
module ptmp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  ptmp_pkg::ptmp_status_t status,
  output ptmp_pkg::ptmp_cmd_t    cmd
);
  import ptmp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd.write_set  = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_issue = 1'b0;
    cmd.commit     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_SET) begin
            cmd.write_set = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The last entry read is compared during this cycle.
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/ptmp_datapath.sv -----
// Datapath: present marks, priority memory, scan compare and result register.
`timescale 1ns / 1ps
module ptmp_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [ptmp_pkg::ID_FIELD_BITS-1:0]   event_id,
  input  logic [ptmp_pkg::PRIO_FIELD_BITS-1:0] priority_req,
  input  ptmp_pkg::ptmp_cmd_t                  cmd,
  output ptmp_pkg::ptmp_status_t               status,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ptmp_pkg::ID_FIELD_BITS-1:0]   polled_id,
  output logic                                 table_empty
);
  import ptmp_pkg::*;

  logic [ID_COUNT-1:0] present_mark;
  prio_t               prio_mem [ID_COUNT];

  id_t   scan_idx;
  id_t   set_idx;
  logic  rd_valid;
  logic  rd_present;
  id_t   rd_id;
  prio_t rd_prio;
  logic  found;
  id_t   best_id;
  prio_t best_prio;
  logic  better;

  assign set_idx = ID_BITS'(event_id);

  assign status.scan_last = (scan_idx == ID_BITS'(ID_COUNT - 1));
  assign status.out_free  = !out_valid || out_ready;

  assign better = rd_valid && rd_present && (!found || (rd_prio > best_prio));

  // Priority memory: one write port for sets, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.write_set) begin
      prio_mem[set_idx] <= PRIORITY_BITS'(priority_req);
    end
    rd_prio <= prio_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_mark <= '0;
    end else begin
      if (cmd.write_set) begin
        present_mark[set_idx] <= 1'b1;
      end
      if (cmd.commit && found) begin
        present_mark[best_id] <= 1'b0;
      end
    end
  end

  // Scan counter and the read-side pipeline register.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_issue;
      if (cmd.scan_start) begin
        scan_idx <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_present <= present_mark[scan_idx];
    rd_id      <= scan_idx;
  end

  // Running best: strict greater-than keeps the smallest id on a tie.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.scan_start) begin
      found <= 1'b0;
    end else if (better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_id   <= rd_id;
      best_prio <= rd_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      polled_id   <= found ? ID_FIELD_BITS'(best_id) : '0;
      table_empty <= !found;
    end
  end

endmodule

// ----- design/priority_table_max_poll.sv -----
// Top level of the indexed max-priority table with poll.
`timescale 1ns / 1ps
// A set request (operation 0) stores the priority of event_id and marks it
// present; it gives no result. A poll request (operation 1) reads every entry
// of the 256-entry priority memory through its single read port, one entry per
// cycle, and the block takes no new request until the poll is finished. The
// result is loaded once the output holds no result that is still waiting to be
// taken. The poll returns the present id with the greatest priority, the
// smallest id on a tie, and removes it; on an empty table it returns table_empty
// high and polled_id zero. All present marks are cleared by reset.
module priority_table_max_poll (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 operation,
  input  logic [ptmp_pkg::ID_FIELD_BITS-1:0]   event_id,
  input  logic [ptmp_pkg::PRIO_FIELD_BITS-1:0] priority_req,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ptmp_pkg::ID_FIELD_BITS-1:0]   polled_id,
  output logic                                 table_empty
);
  import ptmp_pkg::*;

  ptmp_cmd_t    cmd;
  ptmp_status_t status;

  ptmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  ptmp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .event_id     (event_id),
    .priority_req (priority_req),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .polled_id    (polled_id),
    .table_empty  (table_empty)
  );

endmodule
